// File: hw/rtl/tail_servo_force_linearizer_macros.svh
// Assertion macros shared by the tail servo force linearizer RTL.
`ifndef TAIL_SERVO_FORCE_LINEARIZER_MACROS_SVH
`define TAIL_SERVO_FORCE_LINEARIZER_MACROS_SVH
`ifndef SYNTHESIS
`define TSFL_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tsfl check failed");
`define TSFL_CHECK_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tsfl sequence check failed");
`else
`define TSFL_CHECK(lbl, prop)
`define TSFL_CHECK_NEXT(lbl, pre, post)
`endif
`endif

// File: hw/rtl/tsfl_pkg.sv
// Types and constants shared by the tail servo force linearizer modules.
package tsfl_pkg;

  localparam logic [2:0] REG_PWM_LOW    = 3'd0;
  localparam logic [2:0] REG_PWM_CENTER = 3'd1;
  localparam logic [2:0] REG_PWM_HIGH   = 3'd2;
  localparam logic [2:0] REG_TRAVEL     = 3'd3;
  localparam logic [2:0] REG_PEAK_FORCE = 3'd4;

  localparam int DIV_DW = 50;
  localparam int DIV_SW = 34;

  localparam logic [7:0]  DEG_BASE  = 8'd40;
  localparam logic [23:0] ANGLE_MIN = 24'd2621440;
  localparam logic [23:0] ANGLE_MID = 24'd5898240;
  localparam logic [23:0] ANGLE_MAX = 24'd9175040;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_FAULT,
    KIND_CORRECT
  } kind_t;

  typedef struct packed {
    logic [15:0] pwm_low_end;
    logic [15:0] pwm_center;
    logic [15:0] pwm_high_end;
    logic [13:0] servo_travel;
    logic [30:0] peak_yaw_force;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [6:0]         idx;
    logic signed [31:0] force_val;
    logic [15:0]        cmd;
    logic signed [16:0] range;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_DIV1,
    S_WAIT1,
    S_FCK,
    S_LCK,
    S_SRD,
    S_SCK,
    S_GLO,
    S_GHI,
    S_WAIT2,
    S_MAP,
    S_MUL2,
    S_DIV3,
    S_WAIT3,
    S_DONE
  } back_state_t;

endpackage

// File: hw/rtl/tsfl_div.sv
// Restoring divider, one quotient bit per cycle.
module tsfl_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tsfl_pkg::DIV_DW-1:0]    dividend,
  input  logic [tsfl_pkg::DIV_SW-1:0]    divisor,
  output logic                           busy,
  output logic                           done,
  output logic [tsfl_pkg::DIV_DW-1:0]    quotient
);
  localparam int DW = tsfl_pkg::DIV_DW;
  localparam int SW = tsfl_pkg::DIV_SW;
  localparam int CW = $clog2(DW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] dvd_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] dvs_r;
  logic [SW:0]   sh;
  logic [SW:0]   diff;
  logic          ge;

  assign sh   = {rem_r, dvd_r[DW-1]};
  assign diff = sh - {1'b0, dvs_r};
  assign ge   = (sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], ge};
      rem_r <= ge ? diff[SW-1:0] : sh[SW-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dvd_r;
endmodule

// File: hw/rtl/tsfl_front.sv
// Front end: accepts input items and classifies them for the back end.
module tsfl_front #(
  parameter int CURVE_ENTRIES = 100
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tsfl_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_req_type,
  input  logic [6:0]             in_curve_index,
  input  logic signed [31:0]     in_curve_force,
  input  logic [15:0]            in_servo_command,
  output logic                   q_valid,
  input  logic                   q_ready,
  output tsfl_pkg::entry_t       q_data
);
  logic              vld_r, vld_nxt;
  tsfl_pkg::entry_t  ent_r, ent_nxt;
  logic              accept;
  logic              drop;
  logic              mm, below;
  logic signed [16:0] range;

  assign accept = in_valid && in_ready;
  assign in_ready = !vld_r || q_ready;

  always_comb begin
    mm    = cfg.pwm_low_end < cfg.pwm_high_end;
    below = in_servo_command < cfg.pwm_center;
    if (below == mm) begin
      range = $signed({1'b0, cfg.pwm_center}) - $signed({1'b0, cfg.pwm_low_end});
    end else begin
      range = $signed({1'b0, cfg.pwm_high_end}) - $signed({1'b0, cfg.pwm_center});
    end
    ent_nxt.idx       = in_curve_index;
    ent_nxt.force_val = in_curve_force;
    ent_nxt.cmd       = in_servo_command;
    ent_nxt.range     = range;
    drop = 1'b0;
    if (!in_req_type) begin
      ent_nxt.kind = tsfl_pkg::KIND_WRITE;
      drop = ({1'b0, in_curve_index} >= 8'(CURVE_ENTRIES));
    end else if (range == '0 || cfg.servo_travel == '0) begin
      ent_nxt.kind = tsfl_pkg::KIND_FAULT;
    end else begin
      ent_nxt.kind = tsfl_pkg::KIND_CORRECT;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (vld_r && q_ready) begin
      vld_nxt = 1'b0;
    end
    if (accept) begin
      vld_nxt = !drop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_r <= ent_nxt;
    end
  end

  assign q_valid = vld_r;
  assign q_data  = ent_r;
endmodule

// File: hw/rtl/tsfl_queue.sv
// Two-entry queue between front end and back end.
module tsfl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tsfl_pkg::entry_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tsfl_pkg::entry_t out_data
);
  tsfl_pkg::entry_t ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= in_data;
    end
  end
endmodule

// File: hw/rtl/tsfl_back.sv
// Back end: curve memory, force scaling, curve search, interpolation, pulse mapping.
`include "tail_servo_force_linearizer_macros.svh"
module tsfl_back #(
  parameter int CURVE_ENTRIES = 100
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tsfl_pkg::cfg_t   cfg,
  input  logic             q_valid,
  output logic             q_ready,
  input  tsfl_pkg::entry_t q_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      out_corrected_command,
  output logic             out_range_error
);
  localparam int AW = $clog2(CURVE_ENTRIES);

  tsfl_pkg::back_state_t state_r, state_nxt;

  logic signed [31:0] curve_mem [CURVE_ENTRIES];
  logic signed [31:0] rd_data_r;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;

  logic [15:0]        cmd_r;
  logic signed [16:0] range_r;
  logic signed [50:0] prod_r;
  logic signed [50:0] force_r;
  logic               neg_r;
  logic [AW-1:0]      lo_r, hi_r;
  logic signed [31:0] clo_r;
  logic [23:0]        angle_r;
  logic signed [25:0] num_r;
  logic signed [16:0] prange_r;
  logic [15:0]        init_r;
  logic [15:0]        res_cmd_r;
  logic               res_err_r;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_cmd_r;
  logic               out_err_r;

  logic               div_start, div_busy, div_done;
  logic [tsfl_pkg::DIV_DW-1:0] div_dvd, div_q;
  logic [tsfl_pkg::DIV_SW-1:0] div_dvs;

  logic               mm, dneg, out_free;
  logic [15:0]        dabs;
  logic [21:0]        tq;
  logic [21:0]        addend;
  logic signed [50:0] rnum;
  logic [AW:0]        lo_p1, mid_sum;
  logic [AW-1:0]      mid;
  logic signed [32:0] den;
  logic signed [50:0] diff;
  logic               den_pos;
  logic signed [16:0] mag1;
  logic signed [48:0] m1;
  logic signed [42:0] m2;
  logic               alow, sel;
  logic signed [25:0] num_c;
  logic signed [50:0] qs, val;

  always_comb begin
    mm       = cfg.pwm_low_end < cfg.pwm_high_end;
    dneg     = range_r[16];
    dabs     = dneg ? 16'(-range_r) : range_r[15:0];
    tq       = {cfg.servo_travel, 8'd0};
    addend   = (state_r == tsfl_pkg::S_DIV1) ? {6'd0, dabs} : tq;
    rnum     = (prod_r <<< 1) + $signed({29'd0, addend});
    lo_p1    = {1'b0, lo_r} + 1'b1;
    mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
    mid      = mid_sum[AW:1];
    den      = $signed({rd_data_r[31], rd_data_r}) - $signed({clo_r[31], clo_r});
    den_pos  = !den[32] && (den != '0);
    diff     = force_r - 51'(clo_r);
    mag1     = dneg ? ($signed({1'b0, cmd_r}) - $signed({1'b0, cfg.pwm_center}))
                    : ($signed({1'b0, cfg.pwm_center}) - $signed({1'b0, cmd_r}));
    m1       = mag1 * $signed({1'b0, cfg.peak_yaw_force});
    m2       = num_r * prange_r;
    alow     = angle_r < tsfl_pkg::ANGLE_MID;
    sel      = (alow == mm);
    num_c    = sel ? ($signed({2'b0, tsfl_pkg::ANGLE_MID}) + $signed({4'd0, tq})
                      - $signed({2'b0, angle_r}))
                   : ($signed({2'b0, tsfl_pkg::ANGLE_MID}) - $signed({2'b0, angle_r}));
    qs       = neg_r ? ~$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    val      = $signed({35'd0, init_r}) + qs;
    out_free = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsfl_pkg::S_IDLE: begin
        if (q_valid) begin
          case (q_data.kind)
            tsfl_pkg::KIND_FAULT:   state_nxt = tsfl_pkg::S_DONE;
            tsfl_pkg::KIND_CORRECT: state_nxt = tsfl_pkg::S_MUL1;
            default:                state_nxt = tsfl_pkg::S_IDLE;
          endcase
        end
      end
      tsfl_pkg::S_MUL1:  state_nxt = tsfl_pkg::S_DIV1;
      tsfl_pkg::S_DIV1:  state_nxt = tsfl_pkg::S_WAIT1;
      tsfl_pkg::S_WAIT1: if (div_done) state_nxt = tsfl_pkg::S_FCK;
      tsfl_pkg::S_FCK: begin
        state_nxt = (force_r < rd_data_r) ? tsfl_pkg::S_MAP : tsfl_pkg::S_LCK;
      end
      tsfl_pkg::S_LCK: begin
        state_nxt = (force_r >= rd_data_r) ? tsfl_pkg::S_MAP : tsfl_pkg::S_SRD;
      end
      tsfl_pkg::S_SRD: begin
        state_nxt = ({1'b0, hi_r} > lo_p1) ? tsfl_pkg::S_SCK : tsfl_pkg::S_GLO;
      end
      tsfl_pkg::S_SCK:   state_nxt = tsfl_pkg::S_SRD;
      tsfl_pkg::S_GLO:   state_nxt = tsfl_pkg::S_GHI;
      tsfl_pkg::S_GHI:   state_nxt = den_pos ? tsfl_pkg::S_WAIT2 : tsfl_pkg::S_MAP;
      tsfl_pkg::S_WAIT2: if (div_done) state_nxt = tsfl_pkg::S_MAP;
      tsfl_pkg::S_MAP:   state_nxt = tsfl_pkg::S_MUL2;
      tsfl_pkg::S_MUL2:  state_nxt = tsfl_pkg::S_DIV3;
      tsfl_pkg::S_DIV3:  state_nxt = tsfl_pkg::S_WAIT3;
      tsfl_pkg::S_WAIT3: if (div_done) state_nxt = tsfl_pkg::S_DONE;
      tsfl_pkg::S_DONE:  if (out_free) state_nxt = tsfl_pkg::S_IDLE;
      default:           state_nxt = tsfl_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_ready   = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = '0;
    div_start = 1'b0;
    div_dvd   = rnum[49:0];
    div_dvs   = {11'd0, addend, 1'b0};
    if (rnum[50]) begin
      div_dvd = ~rnum[49:0];
    end
    case (state_r)
      tsfl_pkg::S_IDLE: begin
        q_ready = 1'b1;
        mem_we  = q_valid && (q_data.kind == tsfl_pkg::KIND_WRITE);
      end
      tsfl_pkg::S_DIV1: div_start = 1'b1;
      tsfl_pkg::S_FCK:  mem_addr = AW'(CURVE_ENTRIES - 1);
      tsfl_pkg::S_SRD:  mem_addr = ({1'b0, hi_r} > lo_p1) ? mid : lo_r;
      tsfl_pkg::S_GLO:  mem_addr = hi_r;
      tsfl_pkg::S_GHI: begin
        div_start = den_pos;
        div_dvd   = {diff[33:0], 16'd0};
        div_dvs   = {1'b0, den[32:0]};
      end
      tsfl_pkg::S_DIV3: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      curve_mem[q_data.idx[AW-1:0]] <= q_data.force_val;
    end
    rd_data_r <= curve_mem[mem_addr];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == tsfl_pkg::S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsfl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tsfl_pkg::S_IDLE: begin
        cmd_r     <= q_data.cmd;
        range_r   <= q_data.range;
        res_cmd_r <= cfg.pwm_center;
        res_err_r <= 1'b1;
      end
      tsfl_pkg::S_MUL1: prod_r <= 51'(m1);
      tsfl_pkg::S_DIV1: neg_r <= rnum[50];
      tsfl_pkg::S_WAIT1: begin
        force_r <= qs;
        lo_r    <= '0;
        hi_r    <= AW'(CURVE_ENTRIES - 1);
      end
      tsfl_pkg::S_FCK: angle_r <= tsfl_pkg::ANGLE_MIN;
      tsfl_pkg::S_LCK: angle_r <= tsfl_pkg::ANGLE_MAX;
      tsfl_pkg::S_SCK: begin
        if (rd_data_r > force_r) begin
          hi_r <= mid;
        end else begin
          lo_r <= mid;
        end
      end
      tsfl_pkg::S_GLO: clo_r <= rd_data_r;
      tsfl_pkg::S_GHI: angle_r <= {tsfl_pkg::DEG_BASE + 8'(lo_r), 16'd0};
      tsfl_pkg::S_WAIT2: angle_r <= {tsfl_pkg::DEG_BASE + 8'(lo_r), div_q[15:0]};
      tsfl_pkg::S_MAP: begin
        num_r <= num_c;
        if (sel) begin
          prange_r <= $signed({1'b0, cfg.pwm_center}) - $signed({1'b0, cfg.pwm_low_end});
          init_r   <= cfg.pwm_low_end;
        end else begin
          prange_r <= $signed({1'b0, cfg.pwm_high_end}) - $signed({1'b0, cfg.pwm_center});
          init_r   <= cfg.pwm_center;
        end
      end
      tsfl_pkg::S_MUL2: prod_r <= 51'(m2);
      tsfl_pkg::S_DIV3: neg_r <= rnum[50];
      tsfl_pkg::S_WAIT3: begin
        res_err_r <= 1'b0;
        if (val[50]) begin
          res_cmd_r <= 16'd0;
        end else if (val > 51'sd65535) begin
          res_cmd_r <= 16'hFFFF;
        end else begin
          res_cmd_r <= val[15:0];
        end
      end
      tsfl_pkg::S_DONE: begin
        if (out_free) begin
          out_cmd_r <= res_cmd_r;
          out_err_r <= res_err_r;
        end
      end
      default: begin
      end
    endcase
  end

  tsfl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid             = out_valid_r;
  assign out_corrected_command = out_cmd_r;
  assign out_range_error       = out_err_r;

  `TSFL_CHECK(a_div_free, div_start |-> !div_busy)
  `TSFL_CHECK(a_wr_idle, mem_we |-> (state_r == tsfl_pkg::S_IDLE))
  `TSFL_CHECK(a_frac_narrow, (state_r == tsfl_pkg::S_WAIT2 && div_done) |-> (div_q[49:16] == '0))
  `TSFL_CHECK_NEXT(a_done_out, state_r == tsfl_pkg::S_DONE && out_free, out_valid_r)
endmodule

// File: hw/rtl/tail_servo_force_linearizer.sv
// Top level of the tail servo force linearizer: config registers and block wiring.
//
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_ready  | req_type, curve_index, curve_force, servo_command
//  out_     | output    | out_valid/out_ready| corrected_command, range_error
//  cfg_     | input     | cfg_we             | cfg_idx, cfg_wdata
//
// A curve write is handled in the back end's idle state; a correction runs up to three divisions
// on one shared bit-serial divider plus a curve search of up to seven probes.
// The front end and a two-entry queue keep taking items while the back end is busy.
// A finished result waits in the output register without blocking the next item.
// Reset restores the register defaults; curve entries stay undefined until written.
`include "tail_servo_force_linearizer_macros.svh"
module tail_servo_force_linearizer #(
  parameter int CURVE_ENTRIES = 100
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [6:0]         in_curve_index,
  input  logic signed [31:0] in_curve_force,
  input  logic [15:0]        in_servo_command,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_corrected_command,
  output logic               out_range_error
);
  tsfl_pkg::cfg_t   cfg_r, cfg_nxt;
  logic             fq_valid, fq_ready;
  tsfl_pkg::entry_t fq_data;
  logic             qb_valid, qb_ready;
  tsfl_pkg::entry_t qb_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        tsfl_pkg::REG_PWM_LOW:    cfg_nxt.pwm_low_end    = cfg_wdata[15:0];
        tsfl_pkg::REG_PWM_CENTER: cfg_nxt.pwm_center     = cfg_wdata[15:0];
        tsfl_pkg::REG_PWM_HIGH:   cfg_nxt.pwm_high_end   = cfg_wdata[15:0];
        tsfl_pkg::REG_TRAVEL:     cfg_nxt.servo_travel   = cfg_wdata[13:0];
        tsfl_pkg::REG_PEAK_FORCE: cfg_nxt.peak_yaw_force = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_low_end    <= 16'd1000;
      cfg_r.pwm_center     <= 16'd1500;
      cfg_r.pwm_high_end   <= 16'd2000;
      cfg_r.servo_travel   <= 14'd10240;
      cfg_r.peak_yaw_force <= 31'd65536;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tsfl_front #(.CURVE_ENTRIES(CURVE_ENTRIES)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_curve_index   (in_curve_index),
    .in_curve_force   (in_curve_force),
    .in_servo_command (in_servo_command),
    .q_valid          (fq_valid),
    .q_ready          (fq_ready),
    .q_data           (fq_data)
  );

  tsfl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  tsfl_back #(.CURVE_ENTRIES(CURVE_ENTRIES)) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .q_valid               (qb_valid),
    .q_ready               (qb_ready),
    .q_data                (qb_data),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_corrected_command (out_corrected_command),
    .out_range_error       (out_range_error)
  );

  `TSFL_CHECK(a_fault_center, (out_valid && out_range_error) |-> (out_corrected_command == cfg_r.pwm_center))
  `TSFL_CHECK_NEXT(a_cfg_low, cfg_we && cfg_idx == tsfl_pkg::REG_PWM_LOW, cfg_r.pwm_low_end == $past(cfg_wdata[15:0]))
  `TSFL_CHECK_NEXT(a_cfg_travel, cfg_we && cfg_idx == tsfl_pkg::REG_TRAVEL, cfg_r.servo_travel == $past(cfg_wdata[13:0]))
endmodule

// File: tb/tail_servo_force_linearizer_tb.sv
// Self-checking testbench for the tail servo force linearizer.
module tail_servo_force_linearizer_tb;

  localparam int  N_PTS      = 100;
  localparam int  SETTLE     = 400;

  typedef struct {
    logic              req;
    logic [6:0]        idx;
    logic signed [31:0] frc;
    logic [15:0]       cmd;
  } req_t;

  typedef struct {
    logic [15:0] pulse;
    logic        err;
  } pulse_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = tsfl_pkg::REG_PWM_LOW;
  logic [30:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [6:0] in_curve_index = '0;
  logic signed [31:0] in_curve_force = '0;
  logic [15:0] in_servo_command = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_corrected_command;
  logic out_range_error;

  tail_servo_force_linearizer u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_curve_index(in_curve_index), .in_curve_force(in_curve_force),
    .in_servo_command(in_servo_command),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_corrected_command(out_corrected_command), .out_range_error(out_range_error)
  );

  always #4 clk = ~clk;

  // Mirror of the block state
  longint curve_tab[N_PTS];
  longint m_low = 1000, m_ctr = 1500, m_high = 2000, m_trav = 10240, m_peak = 65536;

  req_t   stim_q[$];
  pulse_t pulse_q[$];
  int     mismatches = 0;
  bit     failed = 1'b0;

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic longint rdiv(longint n, longint d);
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    return fdiv(2 * n + d, 2 * d);
  endfunction

  function automatic longint angle_for(longint f);
    int lo_i, hi_i, mid;
    longint den, frac;
    lo_i = 0;
    hi_i = N_PTS - 1;
    if (f < curve_tab[0]) return longint'(tsfl_pkg::ANGLE_MIN);
    if (f >= curve_tab[N_PTS-1]) return longint'(tsfl_pkg::ANGLE_MAX);
    while (hi_i > lo_i + 1) begin
      mid = (lo_i + hi_i) / 2;
      if (curve_tab[mid] > f) hi_i = mid;
      else lo_i = mid;
    end
    den = curve_tab[hi_i] - curve_tab[lo_i];
    frac = 0;
    if (den > 0) frac = ((f - curve_tab[lo_i]) * 65536) / den;
    return longint'(tsfl_pkg::ANGLE_MIN) + longint'(lo_i) * 65536 + frac;
  endfunction

  // Apply one accepted transfer to the mirror; queue the pulse it produces
  function automatic void linearize(req_t r);
    longint cmd, rng, tq, f, ang, num, prng, init, val;
    bit mm, below;
    pulse_t p;
    if (!r.req) begin
      if (r.idx < N_PTS) curve_tab[r.idx] = longint'(r.frc);
      return;
    end
    cmd = longint'(r.cmd);
    mm = m_low < m_high;
    below = cmd < m_ctr;
    rng = (below == mm) ? (m_ctr - m_low) : (m_high - m_ctr);
    tq = m_trav * 256;
    if (rng == 0 || tq == 0) begin
      p.pulse = m_ctr[15:0];
      p.err = 1'b1;
      pulse_q.push_back(p);
      return;
    end
    f = rdiv((m_ctr - cmd) * m_peak, rng);
    ang = angle_for(f);
    if ((ang < longint'(tsfl_pkg::ANGLE_MID)) == mm) begin
      num = longint'(tsfl_pkg::ANGLE_MID) + tq - ang;
      prng = m_ctr - m_low;
      init = m_low;
    end else begin
      num = longint'(tsfl_pkg::ANGLE_MID) - ang;
      prng = m_high - m_ctr;
      init = m_ctr;
    end
    val = init + rdiv(num * prng, tq);
    if (val < 0) val = 0;
    if (val > 65535) val = 65535;
    p.pulse = val[15:0];
    p.err = 1'b0;
    pulse_q.push_back(p);
  endfunction

  // Driver
  req_t cur;
  int   send_gap = 0;
  bit   no_idle = 1'b0;
  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        linearize(cur);
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          cur = stim_q.pop_front();
          in_req_type <= cur.req;
          in_curve_index <= cur.idx;
          in_curve_force <= cur.frc;
          in_servo_command <= cur.cmd;
          in_valid <= 1'b1;
          if ($urandom_range(0, 63) == 0) no_idle = ~no_idle;
          send_gap = no_idle ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  int  recv_gap = 0;
  int  results_seen = 0;
  bit  rx_no_idle = 1'b0;
  always @(posedge clk) begin
    pulse_t exp_p;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pulse_q.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: pulse %0d err %0d",
                     out_corrected_command, out_range_error);
        end else begin
          exp_p = pulse_q.pop_front();
          if (exp_p.pulse !== out_corrected_command || exp_p.err !== out_range_error) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected pulse %0d err %0d, got pulse %0d err %0d",
                       exp_p.pulse, exp_p.err, out_corrected_command, out_range_error);
          end
        end
        // Hold off once for a long stretch so the input side backs up
        if (results_seen == 150) recv_gap = 3000;
        else begin
          if ($urandom_range(0, 63) == 0) rx_no_idle = ~rx_no_idle;
          recv_gap = rx_no_idle ? 0 : $urandom_range(0, 7);
        end
        out_ready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= (recv_gap == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_write(int idx, longint val);
    req_t r;
    r.req = 1'b0;
    r.idx = idx[6:0];
    r.frc = val[31:0];
    r.cmd = $urandom();
    stim_q.push_back(r);
  endtask

  task automatic push_corr(longint cmd);
    req_t r;
    r.req = 1'b1;
    r.idx = $urandom();
    r.frc = $urandom();
    r.cmd = cmd[15:0];
    stim_q.push_back(r);
  endtask

  // Full curve from about -span to +span, occasionally with a dip when bumpy is set
  task automatic load_curve(longint span, bit bumpy);
    longint v;
    if (span < 100) span = 100;
    for (int i = 0; i < N_PTS; i++) begin
      v = -span + (2 * span * i) / (N_PTS - 1) + $urandom_range(0, 15);
      if (bumpy && $urandom_range(0, 7) == 0) v -= longint'($urandom_range(0, 1000000));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      push_write(i, v);
    end
  endtask

  task automatic drain();
    while (stim_q.size() > 0 || in_valid || pulse_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_cfg(longint lo, longint ce, longint hi, longint tr, longint pk);
    logic [30:0] vals[5];
    vals = '{lo[30:0], ce[30:0], hi[30:0], tr[30:0], pk[30:0]};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_idx <= i[2:0];
      cfg_wdata <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    m_low = lo & 16'hFFFF;
    m_ctr = ce & 16'hFFFF;
    m_high = hi & 16'hFFFF;
    m_trav = tr & 14'h3FFF;
    m_peak = pk & 31'h7FFFFFFF;
  endtask

  task automatic random_phase(int n);
    longint c;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        // Point update may break monotonicity; index 100+ is dropped
        push_write($urandom_range(0, 127), longint'(signed'($urandom())) >>> $urandom_range(0, 8));
      end else begin
        if ($urandom_range(0, 4) == 0) c = $urandom_range(0, 65535);
        else if (m_low <= m_high) c = $urandom_range(m_low, m_high);
        else c = $urandom_range(m_high, m_low);
        push_corr(c);
      end
    end
  endtask

  initial begin
    longint lo, ce, hi;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    set_cfg(1000, 1500, 2000, 10240, 65536);

    // Directed: curve, ignored writes, extremes of the command
    load_curve(65536, 1'b0);
    push_write(100, 32'sh7FFFFFFF);
    push_write(127, -64'sd2147483648);
    push_corr(0);
    push_corr(65535);
    push_corr(1000);
    push_corr(1500);
    push_corr(2000);
    push_corr(1250);
    push_corr(1777);
    push_corr(1499);
    push_corr(1501);
    drain();

    set_cfg(2000, 1500, 1000, 10240, 65536);   // inverted channel
    random_phase(120);
    drain();
    set_cfg(0, 32768, 65535, 12800, 2147483647);
    load_curve(2147483647, 1'b0);
    push_write(0, -64'sd2147483648);
    push_write(99, 64'sd2147483647);
    random_phase(150);
    drain();
    set_cfg(1500, 1500, 2000, 1, 0);           // zero low side range, no force
    load_curve(50000, 1'b1);
    random_phase(100);
    drain();
    set_cfg(1000, 1500, 1500, 0, 100000);      // zero travel
    random_phase(60);
    drain();
    for (int ph = 0; ph < 2; ph++) begin
      lo = $urandom_range(0, 65535);
      hi = $urandom_range(0, 65535);
      ce = (lo + hi) / 2 + $urandom_range(0, 200) - 100;
      if (ce < 0) ce = 0;
      if (ce > 65535) ce = 65535;
      set_cfg(lo, ce, hi, $urandom_range(1, 12800), $urandom_range(0, 32'h7FFFFFFF));
      load_curve(m_peak, ph[0]);
      random_phase(154);
      drain();
    end

    if (!failed && mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #24000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
